### src/http_response_stream_parser_assert.svh
// Assertion macros shared by the parser checker.
`ifndef HTTP_RESPONSE_STREAM_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_STREAM_PARSER_ASSERT_SVH

// assertion on i_clk, masked while i_rst_n is low
`define HRSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion on i_clk that also holds across reset
`define HRSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/hrsp_pkg.sv
// Types, constants and prefix tables for the HTTP response stream parser.
package hrsp_pkg;

    localparam int LEN_BITS = 24;
    localparam logic [35:0] LEN_MAX_W = (36'd1 << LEN_BITS) - 36'd1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_MAX_W[LEN_BITS-1:0];

    localparam int LEN_PREFIX_N   = 15;
    localparam int STAMP_PREFIX_N = 21;
    localparam int POS_SAT        = 22;

    localparam int STATUS_W = 11;
    localparam int LENF_W   = LEN_BITS + 1;
    localparam int STAMP_W  = 32;

    // result tdata layout, lowest bit up
    localparam int OFS_BYTE   = 0;
    localparam int OFS_INDEX  = OFS_BYTE + 8;
    localparam int OFS_OK     = OFS_INDEX + LEN_BITS;
    localparam int OFS_STATUS = OFS_OK + 1;
    localparam int OFS_LENF   = OFS_STATUS + STATUS_W;
    localparam int OFS_STAMP  = OFS_LENF + LENF_W;
    localparam int OFS_COUNT  = OFS_STAMP + STAMP_W;
    localparam int OUT_BITS   = OFS_COUNT + LEN_BITS;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_CLOSE = 2'd2
    } t_cmd;

    typedef enum logic {
        KIND_BODY = 1'b0,
        KIND_DONE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_WAIT_SPACE = 2'd0,
        ST_DIGITS     = 2'd1,
        ST_DONE       = 2'd2
    } t_status_phase;

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } t_num_phase;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_UC_A  = 8'd65;
    localparam logic [7:0] CH_UC_Z  = 8'd90;

    function automatic logic [7:0] len_char(input logic [4:0] p);
        case (p)
            5'd0:  len_char = "c";
            5'd1:  len_char = "o";
            5'd2:  len_char = "n";
            5'd3:  len_char = "t";
            5'd4:  len_char = "e";
            5'd5:  len_char = "n";
            5'd6:  len_char = "t";
            5'd7:  len_char = "-";
            5'd8:  len_char = "l";
            5'd9:  len_char = "e";
            5'd10: len_char = "n";
            5'd11: len_char = "g";
            5'd12: len_char = "t";
            5'd13: len_char = "h";
            5'd14: len_char = ":";
            default: len_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] stamp_char(input logic [4:0] p);
        case (p)
            5'd0:  stamp_char = "x";
            5'd1:  stamp_char = "-";
            5'd2:  stamp_char = "r";
            5'd3:  stamp_char = "e";
            5'd4:  stamp_char = "s";
            5'd5:  stamp_char = "p";
            5'd6:  stamp_char = "o";
            5'd7:  stamp_char = "n";
            5'd8:  stamp_char = "s";
            5'd9:  stamp_char = "e";
            5'd10: stamp_char = "-";
            5'd11: stamp_char = "t";
            5'd12: stamp_char = "i";
            5'd13: stamp_char = "m";
            5'd14: stamp_char = "e";
            5'd15: stamp_char = "s";
            5'd16: stamp_char = "t";
            5'd17: stamp_char = "a";
            5'd18: stamp_char = "m";
            5'd19: stamp_char = "p";
            5'd20: stamp_char = ":";
            default: stamp_char = 8'h00;
        endcase
    endfunction

endpackage

### src/http_response_stream_parser.sv
// HTTP/1.1 response stream parser: header parsing and body byte tagging.
//
// Input channel s_axis: one beat per command. tuser carries the command
// (start new response, received byte, connection closed), tdata the byte.
// Output channel m_axis: at most one result beat per input beat, either a
// body byte with its index and store flag (tuser = body) or a completion
// without a byte (tuser = done). tlast marks the beat that ends the response.
// Config channel cfg: writes the store limit in bytes; always ready.
//
// Throughput is one input beat per cycle while the receiver does not stall: the
// parser state and the result register are updated in the same cycle the beat
// is accepted. A result is visible on m_axis in the cycle after its input beat.
// When the receiver stalls, the result is held in the output register and
// s_axis_tready drops until the result is taken; a new beat is accepted in
// the same cycle the held result leaves.
// Synchronous reset clears the parser to await a status line, clears the
// timestamp, sets the store limit to its maximum and empties the output.
module http_response_stream_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // rx_byte
    input  logic [1:0]                    s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // body_byte, body_index, store_ok, status_code, length_field,
    // response_stamp, bytes_counted, zero pad
    output logic [hrsp_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tuser,  // kind
    output logic                          m_axis_tlast,  // last
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hrsp_pkg::LEN_BITS-1:0] i_cfg_data     // store_limit
);
    import hrsp_pkg::*;

    logic [LEN_BITS-1:0] r_store_limit;
    logic                r_in_body, n_in_body;
    logic                r_on_status, n_on_status;
    logic [4:0]          r_pos, n_pos;
    logic                r_began_cr, n_began_cr;
    t_status_phase       r_st_phase, n_st_phase;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_len_ok, n_len_ok;
    logic                r_stamp_ok, n_stamp_ok;
    t_num_phase          r_num_phase, n_num_phase;
    logic                r_neg, n_neg;
    logic [31:0]         r_accum, n_accum;
    logic [LENF_W-1:0]   r_len, n_len;
    logic [31:0]         r_stamp, n_stamp;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic                r_finished, n_finished;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_kind;
    logic                r_out_last;

    logic                accept;
    logic [7:0]          c, lc;
    logic                is_digit, is_ws;
    logic [3:0]          dval;
    logic                len_done, stamp_done, take_digit;
    logic [35:0]         mul10;
    logic [13:0]         st_mul;
    logic                blank;

    logic                res_valid;
    t_kind               res_kind;
    logic [7:0]          res_byte;
    logic [LEN_BITS-1:0] res_idx;
    logic                res_ok;
    logic                res_last;
    logic [STATUS_W-1:0] res_status;
    logic [OUT_W-1:0]    res_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign c        = s_axis_tdata;
    assign lc       = (c >= CH_UC_A && c <= CH_UC_Z) ? c + 8'd32 : c;
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign is_ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign dval     = c[3:0];
    assign len_done   = r_len_ok && (r_pos >= 5'(LEN_PREFIX_N));
    assign stamp_done = r_stamp_ok && (r_pos >= 5'(STAMP_PREFIX_N));
    assign mul10  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + {32'd0, dval};
    assign st_mul = ({4'd0, r_status[9:0]} << 3) + ({4'd0, r_status[9:0]} << 1)
                  + {10'd0, dval};

    always_comb begin
        n_in_body   = r_in_body;
        n_on_status = r_on_status;
        n_pos       = r_pos;
        n_began_cr  = r_began_cr;
        n_st_phase  = r_st_phase;
        n_status    = r_status;
        n_len_ok    = r_len_ok;
        n_stamp_ok  = r_stamp_ok;
        n_num_phase = r_num_phase;
        n_neg       = r_neg;
        n_accum     = r_accum;
        n_len       = r_len;
        n_stamp     = r_stamp;
        n_count     = r_count;
        n_finished  = r_finished;
        take_digit  = 1'b0;
        blank       = 1'b0;
        res_valid   = 1'b0;
        res_kind    = KIND_DONE;
        res_byte    = 8'd0;
        res_idx     = '0;
        res_ok      = 1'b0;
        res_last    = 1'b1;

        case (t_cmd'(s_axis_tuser))
            CMD_START: begin
                n_in_body   = 1'b0;
                n_on_status = 1'b1;
                n_st_phase  = ST_WAIT_SPACE;
                n_status    = '1;
                n_len       = '1;
                n_count     = '0;
                n_finished  = 1'b0;
                n_pos       = '0;
                n_began_cr  = 1'b0;
                n_len_ok    = 1'b1;
                n_stamp_ok  = 1'b1;
                n_num_phase = NUM_SKIP;
                n_neg       = 1'b0;
                n_accum     = '0;
            end
            CMD_CLOSE: begin
                if (!r_finished) begin
                    n_finished = 1'b1;
                    res_valid  = 1'b1;
                end
            end
            CMD_BYTE: begin
                if (!r_finished && r_in_body) begin
                    n_count   = (r_count < LEN_MAX) ? r_count + 1'b1 : r_count;
                    res_valid = 1'b1;
                    res_kind  = KIND_BODY;
                    res_byte  = c;
                    res_idx   = r_count;
                    res_ok    = r_count < r_store_limit;
                    res_last  = !r_len[LENF_W-1] && (n_count >= r_len[LEN_BITS-1:0]);
                    if (res_last) begin
                        n_finished = 1'b1;
                    end
                end else if (!r_finished) begin
                    if (r_on_status) begin
                        case (r_st_phase)
                            ST_WAIT_SPACE: begin
                                if (c == CH_SPACE) begin
                                    n_status   = '0;
                                    n_st_phase = ST_DIGITS;
                                end
                            end
                            ST_DIGITS: begin
                                if (is_digit) begin
                                    n_status = (st_mul > 14'd999) ? STATUS_W'(999)
                                                                  : st_mul[STATUS_W-1:0];
                                end else begin
                                    n_st_phase = ST_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end

                    if (len_done || stamp_done) begin
                        case (r_num_phase)
                            NUM_SKIP: begin
                                if (is_ws) begin
                                end else if (c == CH_MINUS) begin
                                    n_neg       = 1'b1;
                                    n_num_phase = NUM_DIGITS;
                                end else if (c == CH_PLUS) begin
                                    n_num_phase = NUM_DIGITS;
                                end else if (!is_digit) begin
                                    n_num_phase = NUM_DONE;
                                end else begin
                                    n_num_phase = NUM_DIGITS;
                                    take_digit  = 1'b1;
                                end
                            end
                            NUM_DIGITS: begin
                                if (is_digit) begin
                                    take_digit = 1'b1;
                                end else begin
                                    n_num_phase = NUM_DONE;
                                end
                            end
                            default: n_num_phase = NUM_DONE;
                        endcase
                        if (take_digit) begin
                            if (len_done && mul10 > LEN_MAX_W) begin
                                n_accum = LEN_MAX_W[31:0];
                            end else begin
                                n_accum = mul10[31:0];
                            end
                        end
                    end
                    if (!len_done && r_pos < 5'(LEN_PREFIX_N) && lc != len_char(r_pos)) begin
                        n_len_ok = 1'b0;
                    end
                    if (!stamp_done && r_pos < 5'(STAMP_PREFIX_N)
                            && lc != stamp_char(r_pos)) begin
                        n_stamp_ok = 1'b0;
                    end

                    if (c != CH_LF) begin
                        if (r_pos == 5'd0 && c == CH_CR) begin
                            n_began_cr = 1'b1;
                        end
                        if (r_pos < 5'(POS_SAT)) begin
                            n_pos = r_pos + 5'd1;
                        end
                    end else begin
                        if (len_done) begin
                            if (n_neg && n_accum != 32'd0) begin
                                n_len = '1;
                            end else begin
                                n_len = {1'b0, n_accum[LEN_BITS-1:0]};
                            end
                        end
                        if (stamp_done) begin
                            n_stamp = n_neg ? 32'd0 - n_accum : n_accum;
                        end
                        n_on_status = 1'b0;
                        blank       = (r_pos == 5'd0) || (r_pos == 5'd1 && r_began_cr);
                        n_pos       = '0;
                        n_began_cr  = 1'b0;
                        n_len_ok    = 1'b1;
                        n_stamp_ok  = 1'b1;
                        n_num_phase = NUM_SKIP;
                        n_neg       = 1'b0;
                        n_accum     = '0;
                        if (blank) begin
                            n_in_body = 1'b1;
                            if (n_len == '0) begin
                                n_finished = 1'b1;
                                res_valid  = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        res_status = n_on_status ? '1 : n_status;
        res_data = '0;
        res_data[OFS_BYTE +: 8]         = res_byte;
        res_data[OFS_INDEX +: LEN_BITS] = res_idx;
        res_data[OFS_OK]                = res_ok;
        res_data[OFS_STATUS +: STATUS_W] = res_status;
        res_data[OFS_LENF +: LENF_W]    = n_len;
        res_data[OFS_STAMP +: STAMP_W]  = n_stamp;
        res_data[OFS_COUNT +: LEN_BITS] = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_limit <= LEN_MAX;
            r_in_body     <= 1'b0;
            r_on_status   <= 1'b1;
            r_pos         <= '0;
            r_began_cr    <= 1'b0;
            r_st_phase    <= ST_WAIT_SPACE;
            r_status      <= '1;
            r_len_ok      <= 1'b1;
            r_stamp_ok    <= 1'b1;
            r_num_phase   <= NUM_SKIP;
            r_neg         <= 1'b0;
            r_accum       <= '0;
            r_len         <= '1;
            r_stamp       <= '0;
            r_count       <= '0;
            r_finished    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_store_limit <= i_cfg_data;
            end
            if (accept) begin
                r_in_body   <= n_in_body;
                r_on_status <= n_on_status;
                r_pos       <= n_pos;
                r_began_cr  <= n_began_cr;
                r_st_phase  <= n_st_phase;
                r_status    <= n_status;
                r_len_ok    <= n_len_ok;
                r_stamp_ok  <= n_stamp_ok;
                r_num_phase <= n_num_phase;
                r_neg       <= n_neg;
                r_accum     <= n_accum;
                r_len       <= n_len;
                r_stamp     <= n_stamp;
                r_count     <= n_count;
                r_finished  <= n_finished;
            end
            if (accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_data <= res_data;
            r_out_kind <= res_kind;
            r_out_last <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

### src/hrsp_checker.sv
// Port-level checker for the HTTP response stream parser, bound to the top level.
`include "http_response_stream_parser_assert.svh"

module hrsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    // body_byte, body_index, store_ok, status_code, length_field,
    // response_stamp, bytes_counted, zero pad
    input logic [hrsp_pkg::OUT_W-1:0]    m_axis_tdata,
    input logic                          m_axis_tuser,  // kind
    input logic                          m_axis_tlast   // last
);
    import hrsp_pkg::*;

    logic [LEN_BITS-1:0] idx, cnt;
    logic                kind_done, kind_body, rst_cut, stall, head_zero, count_ok;
    logic [OUT_W+1:0]    beat;

    assign idx       = m_axis_tdata[OFS_INDEX +: LEN_BITS];
    assign cnt       = m_axis_tdata[OFS_COUNT +: LEN_BITS];
    assign kind_done = m_axis_tvalid && (m_axis_tuser == KIND_DONE);
    assign kind_body = m_axis_tvalid && (m_axis_tuser == KIND_BODY);
    assign rst_cut   = !i_rst_n;
    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign beat      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign head_zero = (m_axis_tdata[OFS_OK:0] == '0);
    assign count_ok  = (cnt == idx + 1'b1) || (idx == LEN_MAX && cnt == LEN_MAX);

    `HRSP_ASSERT(a_stall_hold, stall |=> m_axis_tvalid && $stable(beat), "stalled beat changed")
    `HRSP_ASSERT(a_done_last, kind_done |-> m_axis_tlast && head_zero, "bad completion beat")
    `HRSP_ASSERT(a_count_idx, kind_body |-> count_ok, "byte count does not follow index")
    `HRSP_ASSERT(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled while empty")
    `HRSP_ASSERT_ALWAYS(a_reset_empty, rst_cut |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind http_response_stream_parser hrsp_checker u_hrsp_checker (.*);
